### rtl/msmg_pkg.sv
// ----------------------------------------------------------------------------
// msmg_pkg: shared types and constants for the mid/side matrix gain block
// Field widths, register map, mode codes and the shared-unit op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package msmg_pkg;

   // sample and gain formats
   localparam int SAMPLE_W   = 24;
   localparam int GAIN_W     = 24;
   localparam int GAIN_FRAC  = 20;
   localparam int BAL_W      = 18;
   localparam int BAL_FRAC   = 16;
   localparam int BAL_G_W    = BAL_FRAC + 1;    // balance gain 0 .. 1.0 (Q1.16)

   // linear ramp length, a power of two
   localparam int RAMP_LEN_LOG2 = 11;
   localparam int RAMP_LEN      = 1 << RAMP_LEN_LOG2;
   localparam int RAMP_CNT_W    = RAMP_LEN_LOG2 + 1;
   localparam int RAMP_W        = GAIN_W + 1;    // signed, holds gains and balance

   // datapath widths
   localparam int INTER_BITS = SAMPLE_W + 4;     // intermediate clamp +-2^28
   localparam int MUL_X_W    = INTER_BITS + 2;
   localparam int MUL_Y_W    = GAIN_W + 1;
   localparam int ACC_W      = MUL_X_W + MUL_Y_W;
   localparam int PROD_W     = SAMPLE_W + 1 + MUL_Y_W;

   localparam logic [GAIN_W-1:0]  GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
   localparam logic [BAL_G_W-1:0] BAL_ONE  = BAL_G_W'(1 << BAL_FRAC);

   // register file
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = CSR_AW - 2;

   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MID_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MID_SOLO    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_SOLO   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BALANCE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_GAIN    = 3'd7;

   // matrix modes
   localparam logic [1:0] MODE_LR_RT   = 2'd0;
   localparam logic [1:0] MODE_MS_LR   = 2'd1;
   localparam logic [1:0] MODE_MS_THRU = 2'd2;
   localparam logic [1:0] MODE_RSVD    = 2'd3;

   // shared unit operations
   localparam logic [2:0] ALU_HOLD = 3'd0;
   localparam logic [2:0] ALU_MUL  = 3'd1;
   localparam logic [2:0] ALU_ADD  = 3'd2;
   localparam logic [2:0] ALU_SUB  = 3'd3;
   localparam logic [2:0] ALU_RND  = 3'd4;

   // rounding shift selection
   localparam logic [1:0] RSH_LR   = 2'd0;   // GAIN_FRAC + 1
   localparam logic [1:0] RSH_GAIN = 2'd1;   // GAIN_FRAC
   localparam logic [1:0] RSH_BAL  = 2'd2;   // BAL_FRAC

   // clamp selection after rounding
   localparam logic [1:0] CLAMP_NONE   = 2'd0;
   localparam logic [1:0] CLAMP_INTER  = 2'd1;
   localparam logic [1:0] CLAMP_SAMPLE = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_a;
      logic signed [SAMPLE_W-1:0] in_b;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_a;
      logic signed [SAMPLE_W-1:0] out_b;
   } rsp_type;

   typedef struct packed {
      logic [1:0]              matrix_mode;
      logic                    bypass_on;
      logic [GAIN_W-1:0]       mid_gain_target;
      logic [GAIN_W-1:0]       side_gain_target;
      logic                    mid_solo_on;
      logic                    side_solo_on;
      logic signed [BAL_W-1:0] balance_target;
      logic [GAIN_W-1:0]       output_gain;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic advance;
   } ramp_ctl_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] rsh;
      logic [1:0] clamp;
   } alu_ctl_type;

endpackage

`default_nettype wire

### rtl/msmg_csr.sv
// ----------------------------------------------------------------------------
// msmg_csr: configuration registers
// APB-style write/read of the eight control registers, one word each.
// ----------------------------------------------------------------------------
`default_nettype none

module msmg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [msmg_pkg::CSR_AW-1:0]        paddr,
   input  logic [msmg_pkg::CSR_DW-1:0]        pwdata,
   output logic [msmg_pkg::CSR_DW-1:0]        prdata,
   output msmg_pkg::cfg_type                  cfg
);

   localparam int DW = msmg_pkg::CSR_DW;
   localparam int GW = msmg_pkg::GAIN_W;
   localparam int BW = msmg_pkg::BAL_W;

   msmg_pkg::cfg_type                  cfg_ff, cfg_in;
   logic [msmg_pkg::CSR_IDX_W-1:0]     idx;
   logic                               wr_en;

   assign idx   = paddr[msmg_pkg::CSR_AW-1:2];
   assign wr_en = psel & penable & pwrite;
   assign cfg   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            msmg_pkg::REG_MATRIX_MODE: cfg_in.matrix_mode      = pwdata[1:0];
            msmg_pkg::REG_BYPASS:      cfg_in.bypass_on        = pwdata[0];
            msmg_pkg::REG_MID_GAIN:    cfg_in.mid_gain_target  = pwdata[GW-1:0];
            msmg_pkg::REG_SIDE_GAIN:   cfg_in.side_gain_target = pwdata[GW-1:0];
            msmg_pkg::REG_MID_SOLO:    cfg_in.mid_solo_on      = pwdata[0];
            msmg_pkg::REG_SIDE_SOLO:   cfg_in.side_solo_on     = pwdata[0];
            msmg_pkg::REG_BALANCE:     cfg_in.balance_target   = $signed(pwdata[BW-1:0]);
            msmg_pkg::REG_OUT_GAIN:    cfg_in.output_gain      = pwdata[GW-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         msmg_pkg::REG_MATRIX_MODE: prdata = DW'(cfg_ff.matrix_mode);
         msmg_pkg::REG_BYPASS:      prdata = DW'(cfg_ff.bypass_on);
         msmg_pkg::REG_MID_GAIN:    prdata = DW'(cfg_ff.mid_gain_target);
         msmg_pkg::REG_SIDE_GAIN:   prdata = DW'(cfg_ff.side_gain_target);
         msmg_pkg::REG_MID_SOLO:    prdata = DW'(cfg_ff.mid_solo_on);
         msmg_pkg::REG_SIDE_SOLO:   prdata = DW'(cfg_ff.side_solo_on);
         msmg_pkg::REG_BALANCE:     prdata = DW'($signed(cfg_ff.balance_target));
         msmg_pkg::REG_OUT_GAIN:    prdata = DW'(cfg_ff.output_gain);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_mode      <= msmg_pkg::MODE_LR_RT;
         cfg_ff.bypass_on        <= 1'b0;
         cfg_ff.mid_gain_target  <= msmg_pkg::GAIN_ONE;
         cfg_ff.side_gain_target <= msmg_pkg::GAIN_ONE;
         cfg_ff.mid_solo_on      <= 1'b0;
         cfg_ff.side_solo_on     <= 1'b0;
         cfg_ff.balance_target   <= '0;
         cfg_ff.output_gain      <= msmg_pkg::GAIN_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/msmg_ramp.sv
// ----------------------------------------------------------------------------
// msmg_ramp: linear gain ramp
// Takes a new target, then steps toward it once per advance over RAMP_LEN.
// ----------------------------------------------------------------------------
`default_nettype none

module msmg_ramp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  msmg_pkg::ramp_ctl_type               ctl,
   input  logic signed [msmg_pkg::RAMP_W-1:0]   init_value,
   input  logic signed [msmg_pkg::RAMP_W-1:0]   target,
   output logic signed [msmg_pkg::RAMP_W-1:0]   now
);

   localparam int RW = msmg_pkg::RAMP_W;
   localparam int CW = msmg_pkg::RAMP_CNT_W;
   localparam logic [CW-1:0]      LEN_CNT   = CW'(msmg_pkg::RAMP_LEN);
   localparam logic signed [RW:0] LEN_ROUND = (RW+1)'(msmg_pkg::RAMP_LEN - 1);

   logic signed [RW-1:0] now_ff, now_in;
   logic signed [RW-1:0] held_ff, held_in;
   logic signed [RW-1:0] step_ff, step_in;
   logic [CW-1:0]        left_ff, left_in;
   logic signed [RW:0]   diff;
   logic signed [RW:0]   quot;

   assign now = now_ff;

   always_comb begin
      diff    = (RW+1)'(target) - (RW+1)'(now_ff);
      // truncate toward zero
      quot    = diff[RW] ? ((diff + LEN_ROUND) >>> msmg_pkg::RAMP_LEN_LOG2)
                         : (diff >>> msmg_pkg::RAMP_LEN_LOG2);
      now_in  = now_ff;
      held_in = held_ff;
      step_in = step_ff;
      left_in = left_ff;
      if (ctl.load) begin
         if (target != held_ff) begin
            held_in = target;
            left_in = LEN_CNT;
            step_in = $signed(quot[RW-1:0]);
         end
      end else if (ctl.advance && (left_ff != '0)) begin
         left_in = left_ff - 1'b1;
         // last step lands exactly on the target
         if (left_ff == CW'(1)) begin
            now_in = held_ff;
         end else begin
            now_in = now_ff + step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff  <= init_value;
         held_ff <= init_value;
         step_ff <= '0;
         left_ff <= '0;
      end else begin
         now_ff  <= now_in;
         held_ff <= held_in;
         step_ff <= step_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

### rtl/msmg_alu.sv
// ----------------------------------------------------------------------------
// msmg_alu: shared multiply / add / round unit
// One signed multiplier, one adder and a round-half-away + clamp stage, all
// writing a single accumulator register.
// ----------------------------------------------------------------------------
`default_nettype none

module msmg_alu (
   input  logic                                 clock,
   input  msmg_pkg::alu_ctl_type                ctl,
   input  logic signed [msmg_pkg::MUL_X_W-1:0]  mul_x,
   input  logic signed [msmg_pkg::MUL_Y_W-1:0]  mul_y,
   input  logic signed [msmg_pkg::ACC_W-1:0]    add_p,
   input  logic signed [msmg_pkg::ACC_W-1:0]    add_q,
   output logic signed [msmg_pkg::ACC_W-1:0]    acc
);

   localparam int AW = msmg_pkg::ACC_W;
   localparam int GF = msmg_pkg::GAIN_FRAC;
   localparam int BF = msmg_pkg::BAL_FRAC;

   localparam logic signed [AW-1:0] HALF_LR   = AW'(1) <<< GF;
   localparam logic signed [AW-1:0] HALF_GAIN = AW'(1) <<< (GF - 1);
   localparam logic signed [AW-1:0] HALF_BAL  = AW'(1) <<< (BF - 1);
   localparam logic signed [AW-1:0] INTER_MAX = (AW'(1) <<< msmg_pkg::INTER_BITS) - AW'(1);
   localparam logic signed [AW-1:0] INTER_MIN = ~INTER_MAX;
   localparam logic signed [AW-1:0] SAMP_MAX  =
      (AW'(1) <<< (msmg_pkg::SAMPLE_W - 1)) - AW'(1);
   localparam logic signed [AW-1:0] SAMP_MIN  = ~SAMP_MAX;

   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] sgn_v;
   logic signed [AW-1:0] rnd_v;
   logic signed [AW-1:0] sat_v;

   assign acc = acc_ff;

   // round to nearest, ties away from zero: negative values add half minus one
   always_comb begin
      sgn_v = $signed({{(AW-1){1'b0}}, acc_ff[AW-1]});
      case (ctl.rsh)
         msmg_pkg::RSH_LR:   rnd_v = (acc_ff + HALF_LR - sgn_v) >>> (GF + 1);
         msmg_pkg::RSH_GAIN: rnd_v = (acc_ff + HALF_GAIN - sgn_v) >>> GF;
         msmg_pkg::RSH_BAL:  rnd_v = (acc_ff + HALF_BAL - sgn_v) >>> BF;
         default:            rnd_v = acc_ff;
      endcase
   end

   always_comb begin
      case (ctl.clamp)
         msmg_pkg::CLAMP_INTER:
            sat_v = (rnd_v > INTER_MAX) ? INTER_MAX :
                    (rnd_v < INTER_MIN) ? INTER_MIN : rnd_v;
         msmg_pkg::CLAMP_SAMPLE:
            sat_v = (rnd_v > SAMP_MAX) ? SAMP_MAX :
                    (rnd_v < SAMP_MIN) ? SAMP_MIN : rnd_v;
         default:
            sat_v = rnd_v;
      endcase
   end

   always_comb begin
      case (ctl.op)
         msmg_pkg::ALU_MUL: acc_in = mul_x * mul_y;
         msmg_pkg::ALU_ADD: acc_in = add_p + add_q;
         msmg_pkg::ALU_SUB: acc_in = add_p - add_q;
         msmg_pkg::ALU_RND: acc_in = sat_v;
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

### rtl/mid_side_matrix_gain.sv
// ----------------------------------------------------------------------------
// mid_side_matrix_gain: stereo mid/side matrix with ramped gains
// Sequencer and operand routing around one shared multiply/round unit.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_ready/req_data) takes one stereo frame:
//    L/R in mode 0, M/S in modes 1 and 2. Response channel (rsp_*) returns
//    one saturated stereo frame per request, in order.
//  - Control registers sit on the APB-style port at byte address 4*index;
//    pready is tied high. Write them only while no request is in flight.
//  - A processed frame goes through these steps from acceptance to rsp_valid:
//    load the ramp targets, advance the ramps, two products (mid and side)
//    plus one capture, then per output channel a sum, a round/clamp, the
//    balance product, its rounding, the output-gain product and the final
//    round/saturate, and a hand-over step. req_ready rises in the same
//    cycle as rsp_valid, so a new frame is taken only after the current one
//    has been handed over.
//  - Bypass (or the unused mode 3) copies the input via the hand-over step,
//    and the next frame again waits for hand-over; ramps are left untouched.
//  - The response sits in an output register. If the receiver stalls, a
//    finished frame waits in the sequencer until the register frees up.
//  - Synchronous active-high reset: registers to defaults (unity gains,
//    centered balance, mode 0), ramps idle, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_side_matrix_gain (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  msmg_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output msmg_pkg::rsp_type                   rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [msmg_pkg::CSR_AW-1:0]         paddr,
   input  logic [msmg_pkg::CSR_DW-1:0]         pwdata,
   output logic [msmg_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);

   localparam int SW  = msmg_pkg::SAMPLE_W;
   localparam int SW1 = SW + 1;
   localparam int RW  = msmg_pkg::RAMP_W;
   localparam int XW  = msmg_pkg::MUL_X_W;
   localparam int YW  = msmg_pkg::MUL_Y_W;
   localparam int AW  = msmg_pkg::ACC_W;
   localparam int PW  = msmg_pkg::PROD_W;
   localparam int BGW = msmg_pkg::BAL_G_W;

   localparam logic signed [RW-1:0] BAL_MAX  = RW'(1 << msmg_pkg::BAL_FRAC);
   localparam logic signed [RW-1:0] BAL_MIN  = -BAL_MAX;
   localparam logic signed [RW-1:0] GAIN_INIT = $signed({1'b0, msmg_pkg::GAIN_ONE});

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SET  = 4'd1;   // take ramp targets
   localparam logic [3:0] S_ADV  = 4'd2;   // advance ramps
   localparam logic [3:0] S_MULM = 4'd3;   // mid product
   localparam logic [3:0] S_MULS = 4'd4;   // side product, latch mid
   localparam logic [3:0] S_CAPS = 4'd5;   // latch side
   localparam logic [3:0] S_SUM  = 4'd6;   // matrix sum/difference
   localparam logic [3:0] S_RND1 = 4'd7;   // round, intermediate clamp
   localparam logic [3:0] S_MBAL = 4'd8;   // balance product
   localparam logic [3:0] S_RND2 = 4'd9;
   localparam logic [3:0] S_MOUT = 4'd10;  // output gain product
   localparam logic [3:0] S_RND3 = 4'd11;  // round, saturate to sample
   localparam logic [3:0] S_DONE = 4'd12;  // hand over to output register

   logic [3:0]             state_ff, state_in;
   logic                   ch_ff, ch_in;          // 0: out_a, 1: out_b
   msmg_pkg::req_type      in_ff, in_in;
   logic signed [PW-1:0]   pm_ff, pm_in;
   logic signed [PW-1:0]   ps_ff, ps_in;
   logic signed [SW-1:0]   res_a_ff, res_a_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   msmg_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   msmg_pkg::cfg_type      cfg;
   msmg_pkg::ramp_ctl_type ms_ctl, bal_ctl;
   msmg_pkg::alu_ctl_type  alu_ctl;

   logic                   bypass_path;
   logic                   thru;
   logic                   lr_mode;
   logic                   out_free;
   logic signed [RW-1:0]   gm_tgt, gs_tgt, bal_tgt;
   logic signed [RW-1:0]   gm_now, gs_now, bal_now;
   logic [BGW-1:0]         lg, rg, bal_g;
   logic signed [SW1-1:0]  sum_ab, dif_ab;
   logic signed [XW-1:0]   mul_x;
   logic signed [YW-1:0]   mul_y;
   logic signed [AW-1:0]   add_p, add_q;
   logic signed [AW-1:0]   acc;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   msmg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   assign bypass_path = cfg.bypass_on || (cfg.matrix_mode == msmg_pkg::MODE_RSVD);
   assign thru        = (cfg.matrix_mode == msmg_pkg::MODE_MS_THRU);
   assign lr_mode     = (cfg.matrix_mode == msmg_pkg::MODE_LR_RT);

   // ------------------------------------------------------------------
   // effective targets: a lone solo mutes the other path; balance clamps
   // to +-1.0
   // ------------------------------------------------------------------
   always_comb begin
      gm_tgt  = $signed({1'b0, cfg.mid_gain_target});
      gs_tgt  = $signed({1'b0, cfg.side_gain_target});
      if (cfg.mid_solo_on && !cfg.side_solo_on) begin
         gs_tgt = '0;
      end else if (cfg.side_solo_on && !cfg.mid_solo_on) begin
         gm_tgt = '0;
      end
      bal_tgt = RW'($signed(cfg.balance_target));
      if (bal_tgt > BAL_MAX) begin
         bal_tgt = BAL_MAX;
      end else if (bal_tgt < BAL_MIN) begin
         bal_tgt = BAL_MIN;
      end
   end

   // mid/side ramps run in every processing mode; balance is frozen in
   // through mode
   assign ms_ctl.load     = (state_ff == S_SET);
   assign ms_ctl.advance  = (state_ff == S_ADV);
   assign bal_ctl.load    = (state_ff == S_SET) && !thru;
   assign bal_ctl.advance = (state_ff == S_ADV) && !thru;

   msmg_ramp u_mid_ramp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ms_ctl),
      .init_value (GAIN_INIT),
      .target     (gm_tgt),
      .now        (gm_now)
   );

   msmg_ramp u_side_ramp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ms_ctl),
      .init_value (GAIN_INIT),
      .target     (gs_tgt),
      .now        (gs_now)
   );

   msmg_ramp u_bal_ramp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bal_ctl),
      .init_value ('0),
      .target     (bal_tgt),
      .now        (bal_now)
   );

   // balance gain: negative balance pulls the right side down, positive
   // the left; through mode leaves both at unity
   always_comb begin
      lg = msmg_pkg::BAL_ONE;
      rg = msmg_pkg::BAL_ONE;
      if (!thru) begin
         if (bal_now[RW-1]) begin
            rg = BGW'(BAL_MAX + bal_now);
         end else if (bal_now != '0) begin
            lg = BGW'(BAL_MAX - bal_now);
         end
      end
      bal_g = ch_ff ? rg : lg;
   end

   // ------------------------------------------------------------------
   // operand routing into the shared unit
   // ------------------------------------------------------------------
   assign sum_ab = SW1'(in_ff.in_a) + SW1'(in_ff.in_b);
   assign dif_ab = SW1'(in_ff.in_a) - SW1'(in_ff.in_b);

   always_comb begin
      unique case (state_ff)
         S_MULM:  mul_x = XW'(lr_mode ? sum_ab : SW1'(in_ff.in_a));
         S_MULS:  mul_x = XW'(lr_mode ? dif_ab : SW1'(in_ff.in_b));
         default: mul_x = $signed(acc[XW-1:0]);   // clamped value fits
      endcase
      unique case (state_ff)
         S_MULM:  mul_y = YW'(gm_now);
         S_MULS:  mul_y = YW'(gs_now);
         S_MBAL:  mul_y = $signed({{(YW-BGW){1'b0}}, bal_g});
         default: mul_y = $signed({1'b0, cfg.output_gain});
      endcase
   end

   // matrix: A = M + S, B = M - S; through mode passes M and S apart
   assign add_p = AW'((thru && ch_ff) ? ps_ff : pm_ff);
   assign add_q = thru ? '0 : AW'(ps_ff);

   always_comb begin
      alu_ctl.op    = msmg_pkg::ALU_HOLD;
      alu_ctl.rsh   = msmg_pkg::RSH_GAIN;
      alu_ctl.clamp = msmg_pkg::CLAMP_NONE;
      unique case (state_ff) inside
         S_MULM, S_MULS, S_MBAL, S_MOUT: begin
            alu_ctl.op = msmg_pkg::ALU_MUL;
         end
         S_SUM: begin
            alu_ctl.op = (!thru && ch_ff) ? msmg_pkg::ALU_SUB : msmg_pkg::ALU_ADD;
         end
         S_RND1: begin
            alu_ctl.op    = msmg_pkg::ALU_RND;
            alu_ctl.rsh   = lr_mode ? msmg_pkg::RSH_LR : msmg_pkg::RSH_GAIN;
            alu_ctl.clamp = msmg_pkg::CLAMP_INTER;
         end
         S_RND2: begin
            alu_ctl.op  = msmg_pkg::ALU_RND;
            alu_ctl.rsh = msmg_pkg::RSH_BAL;
         end
         S_RND3: begin
            alu_ctl.op    = msmg_pkg::ALU_RND;
            alu_ctl.clamp = msmg_pkg::CLAMP_SAMPLE;
         end
         default: begin
            alu_ctl.op = msmg_pkg::ALU_HOLD;
         end
      endcase
   end

   msmg_alu u_alu (
      .clock (clock),
      .ctl   (alu_ctl),
      .mul_x (mul_x),
      .mul_y (mul_y),
      .add_p (add_p),
      .add_q (add_q),
      .acc   (acc)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = bypass_path ? S_DONE : S_SET;
            end
         end
         S_SET:  state_in = S_ADV;
         S_ADV:  state_in = S_MULM;
         S_MULM: state_in = S_MULS;
         S_MULS: state_in = S_CAPS;
         S_CAPS: state_in = S_SUM;
         S_SUM:  state_in = S_RND1;
         S_RND1: state_in = S_MBAL;
         S_MBAL: state_in = S_RND2;
         S_RND2: state_in = S_MOUT;
         S_MOUT: state_in = S_RND3;
         S_RND3: begin
            if (ch_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SUM;
               ch_in    = 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
               ch_in    = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
            ch_in    = 1'b0;
         end
      endcase
   end

   // payload captures
   always_comb begin
      in_in       = in_ff;
      pm_in       = pm_ff;
      ps_in       = ps_ff;
      res_a_in    = res_a_ff;
      rsp_data_in = rsp_data_ff;
      if ((state_ff == S_IDLE) && req_valid) begin
         in_in = req_data;
      end
      if (state_ff == S_MULS) begin
         pm_in = $signed(acc[PW-1:0]);
      end
      if (state_ff == S_CAPS) begin
         ps_in = $signed(acc[PW-1:0]);
      end
      // channel A result is still in the accumulator when B starts
      if ((state_ff == S_SUM) && ch_ff) begin
         res_a_in = $signed(acc[SW-1:0]);
      end
      if ((state_ff == S_DONE) && out_free) begin
         if (bypass_path) begin
            rsp_data_in.out_a = in_ff.in_a;
            rsp_data_in.out_b = in_ff.in_b;
         end else begin
            rsp_data_in.out_a = res_a_ff;
            rsp_data_in.out_b = $signed(acc[SW-1:0]);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      pm_ff       <= pm_in;
      ps_ff       <= ps_in;
      res_a_ff    <= res_a_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside hand-over state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start the sequencer");

   a_idle_channel_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ch_ff)
      else $error("channel select not cleared between requests");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("finished frame dropped while output register full");

endmodule

`default_nettype wire
